[rtl/bloom_filter_ram_node_top_assert.svh]
// ----------------------------------------------------------------------------
// Bloom filter RAM node assertion macros
// Shared property forms for the checker of the Bloom filter RAM node.
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_RAM_NODE_TOP_ASSERT_SVH
`define BLOOM_FILTER_RAM_NODE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFRN_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFRN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bfrn_pkg.sv]
// ----------------------------------------------------------------------------
// Bloom filter RAM node package
// Sizes, field widths, command codes and sequencer states of the node.
// ----------------------------------------------------------------------------
package bfrn_pkg;

    localparam int TUPLE_LEN   = 8;
    localparam int NUM_HASHES  = 3;
    localparam int ADDR_BITS   = 10;
    localparam int CLASS_COUNT = 10;

    localparam int FILTER_ROWS = 1 << ADDR_BITS;
    localparam int HASH_W      = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;
    localparam int POS_W       = (TUPLE_LEN > 1) ? $clog2(TUPLE_LEN) : 1;

    // Fixed field widths of the stream payloads.
    localparam int CMD_W      = 2;
    localparam int TUPLE_W    = 8;
    localparam int CLS_W      = 4;
    localparam int KHASH_W    = 2;
    localparam int KPOS_W     = 3;
    localparam int KVAL_W     = 10;
    localparam int VOTES_W    = 10;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_TRAIN   = 2'd1,
        CMD_PREDICT = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_KEY,
        ST_FRD,
        ST_FWR,
        ST_DONE
    } state_t;

endpackage

[rtl/bloom_filter_ram_node_top.sv]
// ----------------------------------------------------------------------------
// Bloom filter RAM node
// Weightless RAM node with H3 hashing into a Bloom filter store: loads key
// words, trains class bits and predicts the class mask.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                  Payload
// s_axis   in         s_axis_tvalid/tready       tuser command, tdata fields
// m_axis   out        m_axis_tvalid/tready       tdata class_votes
//
// A load is written to the key table on acceptance and leaves the input open.
// Train and predict fetch the first key row (KEY), then for each hash read the
// filter row (FRD) and write it back or fold it into the votes (FWR); a predict
// then loads the output register (DONE) before the input opens again.
// After reset the 2^ADDR_BITS filter rows (1024) are cleared one row a cycle,
// while s_axis_tready stays low.
// A result waits in the output register; a predict that finishes while an
// earlier result is still unread holds until that transaction completes.
// ----------------------------------------------------------------------------
module bloom_filter_ram_node_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tuser: command[1:0]
    input  logic [bfrn_pkg::CMD_W-1:0]         s_axis_tuser,
    // tdata: tuple_bits[7:0], class_index[11:8], key_hash[13:12],
    //        key_position[16:14], key_value[26:17], zero pad[31:27]
    input  logic [bfrn_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: class_votes[9:0], zero pad[15:10]
    output logic [bfrn_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int ADDR_BITS   = bfrn_pkg::ADDR_BITS;
    localparam int CLASS_COUNT = bfrn_pkg::CLASS_COUNT;
    localparam int TUPLE_LEN   = bfrn_pkg::TUPLE_LEN;
    localparam int HASH_W      = bfrn_pkg::HASH_W;
    localparam int POS_W       = bfrn_pkg::POS_W;

    // Input field slices.
    logic [bfrn_pkg::TUPLE_W-1:0] in_tuple;
    logic [bfrn_pkg::CLS_W-1:0]   in_class;
    logic [bfrn_pkg::KHASH_W-1:0] in_khash;
    logic [bfrn_pkg::KPOS_W-1:0]  in_kpos;
    logic [bfrn_pkg::KVAL_W-1:0]  in_kval;
    bfrn_pkg::cmd_t               in_cmd;

    assign in_tuple = s_axis_tdata[7:0];
    assign in_class = s_axis_tdata[11:8];
    assign in_khash = s_axis_tdata[13:12];
    assign in_kpos  = s_axis_tdata[16:14];
    assign in_kval  = s_axis_tdata[26:17];
    assign in_cmd   = bfrn_pkg::cmd_t'(s_axis_tuser);

    // Memories.
    logic [TUPLE_LEN-1:0][ADDR_BITS-1:0] key_mem [bfrn_pkg::NUM_HASHES];
    logic [CLASS_COUNT-1:0]              filt_mem [bfrn_pkg::FILTER_ROWS];

    // Registers.
    bfrn_pkg::state_t              state_reg, state_next;
    logic [HASH_W-1:0]             hash_reg, hash_next;
    logic [ADDR_BITS-1:0]          clr_reg, clr_next;
    logic [ADDR_BITS-1:0]          addr_reg, addr_next;
    logic [TUPLE_LEN-1:0]          tuple_reg, tuple_next;
    logic [bfrn_pkg::CLS_W-1:0]    class_reg, class_next;
    logic                          train_reg, train_next;
    logic [CLASS_COUNT-1:0]        votes_reg, votes_next;
    logic                          oval_reg, oval_next;
    logic [bfrn_pkg::VOTES_W-1:0]  odata_reg, odata_next;
    logic [TUPLE_LEN-1:0][ADDR_BITS-1:0] key_rd_reg;
    logic [CLASS_COUNT-1:0]        filt_rd_reg;

    // Combinational controls.
    logic                   s_accept;
    logic                   key_we;
    logic [HASH_W-1:0]      key_raddr;
    logic                   filt_we;
    logic [ADDR_BITS-1:0]   filt_waddr;
    logic [CLASS_COUNT-1:0] filt_wdata;
    logic [ADDR_BITS-1:0]   hash_addr;
    logic [CLASS_COUNT-1:0] class_mask;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign key_we   = s_accept && (in_cmd == bfrn_pkg::CMD_LOAD)
                      && (32'(in_khash) < bfrn_pkg::NUM_HASHES)
                      && (32'(in_kpos) < TUPLE_LEN);

    // H3 hash: XOR of the key words whose tuple bit is set.
    always_comb
    begin
        hash_addr = '0;
        for (int n = 0; n < TUPLE_LEN; n++)
        begin
            if (tuple_reg[n])
            begin
                hash_addr = hash_addr ^ key_rd_reg[n];
            end
        end
    end

    // An out-of-range class leaves the mask empty, so a train changes nothing.
    always_comb
    begin
        for (int i = 0; i < CLASS_COUNT; i++)
        begin
            class_mask[i] = (32'(class_reg) == i);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        hash_next     = hash_reg;
        clr_next      = clr_reg;
        addr_next     = addr_reg;
        tuple_next    = tuple_reg;
        class_next    = class_reg;
        train_next    = train_reg;
        votes_next    = votes_reg;
        odata_next    = odata_reg;
        oval_next     = oval_reg && !m_axis_tready;
        s_axis_tready = 1'b0;
        key_raddr     = hash_reg;
        filt_we       = 1'b0;
        filt_waddr    = addr_reg;
        filt_wdata    = filt_rd_reg | class_mask;

        case (state_reg)
            bfrn_pkg::ST_CLEAR:
            begin
                filt_we    = 1'b1;
                filt_waddr = clr_reg;
                filt_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = bfrn_pkg::ST_IDLE;
                end
            end
            bfrn_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid
                    && (in_cmd == bfrn_pkg::CMD_TRAIN || in_cmd == bfrn_pkg::CMD_PREDICT))
                begin
                    tuple_next = in_tuple[TUPLE_LEN-1:0];
                    class_next = in_class;
                    train_next = (in_cmd == bfrn_pkg::CMD_TRAIN);
                    hash_next  = '0;
                    votes_next = '1;
                    state_next = bfrn_pkg::ST_KEY;
                end
            end
            bfrn_pkg::ST_KEY:
            begin
                state_next = bfrn_pkg::ST_FRD;
            end
            bfrn_pkg::ST_FRD:
            begin
                addr_next  = hash_addr;
                state_next = bfrn_pkg::ST_FWR;
            end
            bfrn_pkg::ST_FWR:
            begin
                if (train_reg)
                begin
                    filt_we = 1'b1;
                end
                else
                begin
                    votes_next = votes_reg & filt_rd_reg;
                end
                if (32'(hash_reg) == bfrn_pkg::NUM_HASHES - 1)
                begin
                    state_next = train_reg ? bfrn_pkg::ST_IDLE : bfrn_pkg::ST_DONE;
                end
                else
                begin
                    // Fetch the next key row while this filter row is written back or folded into the votes.
                    hash_next  = hash_reg + 1'b1;
                    key_raddr  = hash_reg + 1'b1;
                    state_next = bfrn_pkg::ST_FRD;
                end
            end
            bfrn_pkg::ST_DONE:
            begin
                if (!oval_reg || m_axis_tready)
                begin
                    oval_next  = 1'b1;
                    odata_next = bfrn_pkg::VOTES_W'(votes_reg);
                    state_next = bfrn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bfrn_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfrn_pkg::ST_CLEAR;
            hash_reg  <= '0;
            clr_reg   <= '0;
            train_reg <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hash_reg  <= hash_next;
            clr_reg   <= clr_next;
            train_reg <= train_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        tuple_reg <= tuple_next;
        class_reg <= class_next;
        votes_reg <= votes_next;
        odata_reg <= odata_next;
    end

    // Key table: one row per hash, one word written per load.
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[in_khash[HASH_W-1:0]][in_kpos[POS_W-1:0]] <= in_kval[ADDR_BITS-1:0];
        end
        key_rd_reg <= key_mem[key_raddr];
    end

    // Filter store: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (filt_we)
        begin
            filt_mem[filt_waddr] <= filt_wdata;
        end
        filt_rd_reg <= filt_mem[hash_addr];
    end

    assign m_axis_tvalid = oval_reg;
    assign m_axis_tdata  = {{(bfrn_pkg::OUT_TDATA_W - bfrn_pkg::VOTES_W){1'b0}}, odata_reg};

endmodule

[rtl/bfrn_checker.sv]
// ----------------------------------------------------------------------------
// Bloom filter RAM node checker
// Port-level assertions on the node's stream channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "bloom_filter_ram_node_top_assert.svh"

module bfrn_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [bfrn_pkg::CMD_W-1:0]         s_axis_tuser,
    input logic [bfrn_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [bfrn_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    logic s_accept;
    logic hashed_cmd;

    assign s_accept   = s_axis_tvalid && s_axis_tready;
    assign hashed_cmd = (s_axis_tuser == bfrn_pkg::CMD_TRAIN)
                        || (s_axis_tuser == bfrn_pkg::CMD_PREDICT);

    // A stalled result transaction keeps its data.
    `BFRN_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // Pad bits above the class votes stay zero.
    `BFRN_ASSERT_SAME(a_out_pad, m_axis_tvalid, m_axis_tdata[15:10] == 6'd0, "nonzero pad bits in result")

    // Train and predict occupy the filter store, so the input closes next cycle.
    `BFRN_ASSERT_NEXT(a_busy_after_hash, s_accept && hashed_cmd, !s_axis_tready, "input ready during a hash walk")

    // A key load completes at once and leaves the input open.
    `BFRN_ASSERT_NEXT(a_ready_after_load, s_accept && (s_axis_tuser == bfrn_pkg::CMD_LOAD), s_axis_tready, "input not ready after a key load")

endmodule

bind bloom_filter_ram_node_top bfrn_checker u_bfrn_checker (.*);

[tb/tb_bloom_filter_ram_node_top.sv]
// ----------------------------------------------------------------------------
// Bloom filter RAM node testbench
// Streams key loads, training and prediction commands into the node and
// checks every class vote mask against a cycle-free predictor that keeps its
// own key table and filter store. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bloom_filter_ram_node_top;

    localparam int CMD_W       = bfrn_pkg::CMD_W;
    localparam int TUPLE_W     = bfrn_pkg::TUPLE_W;
    localparam int CLS_W       = bfrn_pkg::CLS_W;
    localparam int KHASH_W     = bfrn_pkg::KHASH_W;
    localparam int KPOS_W      = bfrn_pkg::KPOS_W;
    localparam int KVAL_W      = bfrn_pkg::KVAL_W;
    localparam int VOTES_W     = bfrn_pkg::VOTES_W;
    localparam int IN_TDATA_W  = bfrn_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = bfrn_pkg::OUT_TDATA_W;
    localparam int ADDR_BITS   = bfrn_pkg::ADDR_BITS;
    localparam int NUM_HASHES  = bfrn_pkg::NUM_HASHES;
    localparam int TUPLE_LEN   = bfrn_pkg::TUPLE_LEN;
    localparam int CLASS_COUNT = bfrn_pkg::CLASS_COUNT;
    localparam int FILTER_ROWS = bfrn_pkg::FILTER_ROWS;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 1800;
    localparam int QUIET_TAIL   = 200;
    localparam int HOLD_AT      = 600;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [TUPLE_W-1:0] tuple_bits;
        logic [CLS_W-1:0]   class_index;
        logic [KHASH_W-1:0] key_hash;
        logic [KPOS_W-1:0]  key_pos;
        logic [KVAL_W-1:0]  key_value;
    } node_cmd_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [CMD_W-1:0]       s_axis_tuser = '0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    bloom_filter_ram_node_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predictor state.
    logic [ADDR_BITS-1:0]   key_words [NUM_HASHES][TUPLE_LEN];
    logic [CLASS_COUNT-1:0] filter_rows [FILTER_ROWS];
    logic [VOTES_W-1:0]     votes_due[$];

    node_cmd_t pending[$];
    node_cmd_t cur;
    logic      in_taken = 1'b0;
    int        n_pushed = 0;
    int        n_taken = 0;
    int        gap_left = 0;
    int        stall_left = 0;
    int        run_left = 0;
    int        hold_left = 0;
    logic      hold_done = 1'b0;
    logic      quiet_tail = 1'b0;

    int errors = 0;
    int n_load = 0;
    int n_train = 0;
    int n_predict = 0;
    int n_ignored = 0;
    int n_checked = 0;
    int n_hits = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [ADDR_BITS-1:0] h3_address(input logic [TUPLE_W-1:0] bits,
                                                         input int h);
        logic [ADDR_BITS-1:0] acc;
        acc = '0;
        for (int n = 0; n < TUPLE_LEN; n++)
            if (bits[n])
                acc ^= key_words[h][n];
        return acc;
    endfunction

    task automatic node_apply(input node_cmd_t it);
        logic [CLASS_COUNT-1:0] votes;
        case (it.cmd)
            bfrn_pkg::CMD_LOAD:
            begin
                if (it.key_hash < NUM_HASHES && it.key_pos < TUPLE_LEN)
                begin
                    key_words[it.key_hash][it.key_pos] = it.key_value[ADDR_BITS-1:0];
                    n_load++;
                end
                else
                begin
                    n_ignored++;
                end
            end
            bfrn_pkg::CMD_TRAIN:
            begin
                n_train++;
                if (it.class_index < CLASS_COUNT)
                    for (int h = 0; h < NUM_HASHES; h++)
                        filter_rows[h3_address(it.tuple_bits, h)][it.class_index] = 1'b1;
            end
            bfrn_pkg::CMD_PREDICT:
            begin
                n_predict++;
                votes = '1;
                for (int h = 0; h < NUM_HASHES; h++)
                    votes &= filter_rows[h3_address(it.tuple_bits, h)];
                votes_due.insert(votes_due.size(), VOTES_W'(votes));
            end
            default: n_ignored++;
        endcase
    endtask

    function automatic node_cmd_t make_cmd(input logic [CMD_W-1:0] cmd,
                                           input logic [TUPLE_W-1:0] bits,
                                           input logic [CLS_W-1:0] cls,
                                           input logic [KHASH_W-1:0] kh,
                                           input logic [KPOS_W-1:0] kp,
                                           input logic [KVAL_W-1:0] kv);
        node_cmd_t it;
        it.cmd = cmd;
        it.tuple_bits = bits;
        it.class_index = cls;
        it.key_hash = kh;
        it.key_pos = kp;
        it.key_value = kv;
        return it;
    endfunction

    function automatic node_cmd_t random_fields();
        return make_cmd(CMD_W'($urandom_range(0, 3)), TUPLE_W'($urandom_range(0, 255)),
                        CLS_W'($urandom_range(0, 15)), KHASH_W'($urandom_range(0, 3)),
                        KPOS_W'($urandom_range(0, 7)), KVAL_W'($urandom_range(0, 1023)));
    endfunction

    task automatic enqueue(input node_cmd_t it);
        pending.insert(pending.size(), it);
    endtask

    // Sender: a new item goes out once the previous transaction completed.
    always @(negedge clk)
    begin
        logic next_valid;
        next_valid = s_axis_tvalid && !in_taken;
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (gap_left != 0)
            begin
                gap_left--;
            end
            else if (pending.size() != 0)
            begin
                cur = pending.pop_front();
                s_axis_tuser <= cur.cmd;
                s_axis_tdata <= {5'b0, cur.key_value, cur.key_pos, cur.key_hash,
                                 cur.class_index, cur.tuple_bits};
                next_valid = 1'b1;
                if (!quiet_tail && $urandom_range(0, 5) == 0)
                    gap_left = $urandom_range(1, 7);
            end
        end
        s_axis_tvalid <= next_valid;
    end

    // Receiver: stall bursts alternate with stretches of steady readiness.
    always @(negedge clk)
    begin
        logic rdy;
        if (stall_left == 0 && run_left == 0)
        begin
            if ($urandom_range(0, 2) == 0)
                stall_left = $urandom_range(1, 7);
            else
                run_left = $urandom_range(1, 40);
        end
        if (stall_left != 0)
        begin
            stall_left--;
            rdy = 1'b0;
        end
        else
        begin
            run_left--;
            rdy = 1'b1;
        end
        if (!rst_n || hold_left != 0)
            rdy = 1'b0;
        else if (quiet_tail)
            rdy = 1'b1;
        m_axis_tready <= rdy;
    end

    // One long output hold-off while the sender keeps offering items.
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && n_taken >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        logic [OUT_TDATA_W-1:0] want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (votes_due.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("ERROR: unexpected result, class_votes=%h",
                                 m_axis_tdata[VOTES_W-1:0]);
                end
                else
                begin
                    want = OUT_TDATA_W'(votes_due.pop_front());
                    n_checked++;
                    if (want != '0)
                        n_hits++;
                    if (m_axis_tdata !== want)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("ERROR: result %0d class_votes expected %h, got %h",
                                     n_checked, want, m_axis_tdata);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                node_apply(cur);
                in_taken <= 1'b1;
                n_taken <= n_taken + 1;
            end
            else
            begin
                in_taken <= 1'b0;
            end
        end
    end

    initial
    begin
        node_cmd_t it;
        logic [TUPLE_W-1:0] trained[$];
        int made;
        int pick;

        foreach (filter_rows[r])
            filter_rows[r] = '0;
        foreach (key_words[h, p])
            key_words[h][p] = '0;

        // An empty tuple touches no key word, so it may be predicted first.
        enqueue(make_cmd(bfrn_pkg::CMD_PREDICT, 8'h00, 4'd0, 2'd0, 3'd0, 10'd0));
        for (int h = 0; h < NUM_HASHES; h++)
            for (int p = 0; p < TUPLE_LEN; p++)
            begin
                it = random_fields();
                it.cmd = bfrn_pkg::CMD_LOAD;
                it.key_hash = KHASH_W'(h);
                it.key_pos = KPOS_W'(p);
                if (h == 0 && p == 0)
                    it.key_value = '1;
                else if (h == 0 && p == 1)
                    it.key_value = '0;
                enqueue(it);
            end
        // A load to a hash beyond the table and an unused command are ignored.
        it = random_fields();
        it.cmd = bfrn_pkg::CMD_LOAD;
        it.key_hash = '1;
        enqueue(it);
        it = random_fields();
        it.cmd = CMD_SPARE;
        enqueue(it);
        enqueue(make_cmd(bfrn_pkg::CMD_TRAIN, 8'hFF, 4'd0, 2'd0, 3'd0, 10'd0));
        enqueue(make_cmd(bfrn_pkg::CMD_TRAIN, 8'hFF, CLS_W'(CLASS_COUNT - 1), '1, '1, '1));
        enqueue(make_cmd(bfrn_pkg::CMD_TRAIN, 8'h00, 4'd5, 2'd0, 3'd0, 10'd0));
        enqueue(make_cmd(bfrn_pkg::CMD_TRAIN, 8'h01, '1, 2'd0, 3'd0, 10'd0));
        enqueue(make_cmd(bfrn_pkg::CMD_PREDICT, 8'hFF, 4'd0, 2'd0, 3'd0, 10'd0));
        enqueue(make_cmd(bfrn_pkg::CMD_PREDICT, 8'h00, '1, '1, '1, '1));
        enqueue(make_cmd(bfrn_pkg::CMD_PREDICT, 8'h01, 4'd0, 2'd0, 3'd0, 10'd0));
        enqueue(make_cmd(bfrn_pkg::CMD_PREDICT, 8'h80, 4'd0, 2'd0, 3'd0, 10'd0));
        n_pushed = pending.size();
        trained.insert(trained.size(), 8'hFF);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The sender waits here until the directed results are all back.
        while (n_taken != n_pushed || votes_due.size() != 0)
            @(negedge clk);

        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            it = random_fields();
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                it.cmd = bfrn_pkg::CMD_LOAD;
                it.key_hash = KHASH_W'($urandom_range(0, NUM_HASHES - 1));
                made++;
            end
            else if (pick < 8)
            begin
                it.cmd = bfrn_pkg::CMD_LOAD;
                it.key_hash = '1;
            end
            else if (pick < 10)
            begin
                it.cmd = CMD_SPARE;
            end
            else if (pick < 52)
            begin
                it.cmd = bfrn_pkg::CMD_TRAIN;
                if ($urandom_range(0, 2) == 0)
                    it.tuple_bits = trained[$urandom_range(0, trained.size() - 1)];
                if ($urandom_range(0, 9) != 0)
                    it.class_index = CLS_W'($urandom_range(0, CLASS_COUNT - 1));
                trained.insert(trained.size(), it.tuple_bits);
                if (trained.size() > 48)
                    void'(trained.pop_front());
                made++;
            end
            else
            begin
                it.cmd = bfrn_pkg::CMD_PREDICT;
                if ($urandom_range(0, 9) < 6)
                begin
                    it.tuple_bits = trained[$urandom_range(0, trained.size() - 1)];
                    if ($urandom_range(0, 3) == 0)
                        it.tuple_bits[$urandom_range(0, TUPLE_W - 1)] ^= 1'b1;
                end
                made++;
            end
            enqueue(it);
            n_pushed++;
        end

        while (pending.size() >= QUIET_TAIL)
            @(posedge clk);
        quiet_tail = 1'b1;

        while (n_taken != n_pushed || votes_due.size() != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);

        if (votes_due.size() != 0)
            errors += votes_due.size();
        $display("Run covered %0d key loads, %0d trains, %0d predicts, %0d ignored items.",
                 n_load, n_train, n_predict, n_ignored);
        $display("Checked %0d class vote masks, %0d of them with classes present.",
                 n_checked, n_hits);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Timeout: %0d of %0d items accepted, %0d results outstanding.",
                 n_taken, n_pushed, votes_due.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
